// File: rtl/sif_pkg.sv
package sif_pkg;

  // default sizes
  localparam int SIF_MAX_MODES   = 256;
  localparam int SIF_VALUE_WIDTH = 32;

  // unsigned q0.32-scaled constants, ONE_Q32 on 33 bits
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
  localparam int          EXP_TERMS = 12;
  localparam int          MAX_SHIFT = 32;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FIRST_STEP   = 3'd0,
    CFG_TIME_STEP    = 3'd1,
    CFG_VISCOUS_RATE = 3'd2,
    CFG_MODE_COUNT   = 3'd3
  } cfg_reg_t;

  // j * ln2 on 37 bits, j up to 33
  function automatic logic [36:0] ln2_mul(input logic [5:0] j);
    ln2_mul = 37'(j) * 37'(LN2_Q32);
  endfunction

  // reciprocal multiplier giving floor(p / n) exactly for 32 bit p
  function automatic logic [32:0] recip_mul(input int n);
    case (n)
      3:       recip_mul = 33'h1_5555_5556;
      5:       recip_mul = 33'h1_9999_999A;
      6:       recip_mul = 33'h1_5555_5556;
      7:       recip_mul = 33'h1_2492_4925;
      9:       recip_mul = 33'h1_C71C_71C8;
      10:      recip_mul = 33'h1_9999_999A;
      11:      recip_mul = 33'h1_745D_1746;
      12:      recip_mul = 33'h1_5555_5556;
      default: recip_mul = 33'h1_0000_0000;
    endcase
  endfunction

  // matching right shift, 32 plus ceil(log2 n)
  function automatic int recip_shift(input int n);
    case (n)
      1:                recip_shift = 32;
      2:                recip_shift = 33;
      3, 4:             recip_shift = 34;
      5, 6, 7, 8:       recip_shift = 35;
      default:          recip_shift = 36;
    endcase
  endfunction

endpackage

// File: rtl/sif_front.sv
module sif_front
  import sif_pkg::*;
#(
  parameter int VALUE_WIDTH = SIF_VALUE_WIDTH,
  parameter int SW          = 6 * VALUE_WIDTH + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [7:0]                  wave_a,
  input  logic [7:0]                  wave_b,
  input  logic [7:0]                  wave_c,
  input  logic [6*VALUE_WIDTH-1:0]    pay,
  input  logic [8:0]                  k_i,
  input  logic [9:0]                  lim_i,
  input  logic [31:0]                 viscous_rate,
  output logic                        out_valid,
  output logic [49:0]                 x_o,
  output logic [SW-1:0]               side_o
);

  logic                     v0_r, v1_r, v2_r;
  logic [7:0]               a_r, b_r, c_r;
  logic [6*VALUE_WIDTH-1:0] pay0_r, pay1_r;
  logic [17:0]              ksq_r, ksq_nxt;
  logic                     keep_r, keep_nxt;
  logic [49:0]              x_r, x_nxt;
  logic [SW-1:0]            side_r;

  // retained set test and squared magnitude
  always_comb begin
    keep_nxt = ({1'b0, a_r} < k_i) && ({1'b0, b_r} < k_i) && ({1'b0, c_r} < k_i) &&
               ((a_r | b_r | c_r) != 8'd0) &&
               ({1'b0, 9'(a_r) + 9'(b_r)} <= lim_i) &&
               ({1'b0, 9'(a_r) + 9'(c_r)} <= lim_i) &&
               ({1'b0, 9'(b_r) + 9'(c_r)} <= lim_i);
    ksq_nxt  = 18'(a_r) * 18'(a_r) + 18'(b_r) * 18'(b_r) + 18'(c_r) * 18'(c_r);
  end

  // decay exponent
  always_comb begin
    x_nxt = 50'(ksq_r) * 50'(viscous_rate);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= wave_a;
      b_r    <= wave_b;
      c_r    <= wave_c;
      pay0_r <= pay;
      ksq_r  <= ksq_nxt;
      keep_r <= keep_nxt;
      pay1_r <= pay0_r;
      x_r    <= x_nxt;
      side_r <= {keep_r, pay1_r};
    end
  end

  assign out_valid = v2_r;
  assign x_o       = x_r;
  assign side_o    = side_r;

endmodule

// File: rtl/sif_decay.sv
module sif_decay
  import sif_pkg::*;
#(
  parameter int SW = 6 * SIF_VALUE_WIDTH + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [49:0]   x_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid,
  output logic [32:0]   e_o,
  output logic [SW-1:0] side_o
);

  // range reduction compare stage
  logic          va_r, zero_a_r;
  logic [32:1]   ge_a_r, ge_nxt;
  logic [36:0]   xl_a_r;
  logic [SW-1:0] side_a_r;
  logic          zero_nxt;

  always_comb begin
    zero_nxt = x_i >= 50'(ln2_mul(6'(MAX_SHIFT + 1)));
    for (int j = 1; j <= MAX_SHIFT; j++) begin
      ge_nxt[j] = x_i[36:0] >= ln2_mul(6'(j));
    end
  end

  // series stage carriers, index i is the input of term i
  logic          s_v_r    [0:EXP_TERMS];
  logic          s_zero_r [0:EXP_TERMS];
  logic [5:0]    s_q_r    [0:EXP_TERMS];
  logic [31:0]   s_r_r    [0:EXP_TERMS];
  logic [SW-1:0] s_side_r [0:EXP_TERMS];
  logic [32:0]   t_r      [1:EXP_TERMS];

  logic [5:0]    q_nxt;
  logic [36:0]   rem_nxt;

  // quotient from thermometer code, remainder by one subtract
  always_comb begin
    q_nxt   = 6'($countones(ge_a_r));
    rem_nxt = xl_a_r - ln2_mul(q_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      s_v_r[0] <= 1'b0;
    end else if (en) begin
      va_r     <= in_valid;
      s_v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_a_r    <= zero_nxt;
      ge_a_r      <= ge_nxt;
      xl_a_r      <= x_i[36:0];
      side_a_r    <= side_i;
      s_zero_r[0] <= zero_a_r;
      s_q_r[0]    <= q_nxt;
      s_r_r[0]    <= rem_nxt[31:0];
      s_side_r[0] <= side_a_r;
    end
  end

  // taylor terms, highest order first, two stages each
  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_term
    localparam int          N  = EXP_TERMS - i;
    localparam logic [32:0] M  = recip_mul(N);
    localparam int          SH = recip_shift(N);

    logic          m_v_r, m_zero_r;
    logic [5:0]    m_q_r;
    logic [31:0]   m_r_r, m_p_r;
    logic [SW-1:0] m_side_r;
    logic [32:0]   t_in;
    logic [64:0]   mprod, dprod;
    logic [31:0]   quot;

    if (i == 0) begin : g_first
      assign t_in = ONE_Q32;
    end else begin : g_next
      assign t_in = t_r[i];
    end

    // r * t
    assign mprod = 65'(s_r_r[i]) * 65'(t_in);
    // divide by the term number
    assign dprod = 65'(m_p_r) * 65'(M);
    assign quot  = 32'(dprod >> SH);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_v_r      <= 1'b0;
        s_v_r[i+1] <= 1'b0;
      end else if (en) begin
        m_v_r      <= s_v_r[i];
        s_v_r[i+1] <= m_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_p_r         <= mprod[63:32];
        m_r_r         <= s_r_r[i];
        m_q_r         <= s_q_r[i];
        m_zero_r      <= s_zero_r[i];
        m_side_r      <= s_side_r[i];
        t_r[i+1]      <= ONE_Q32 - 33'(quot);
        s_r_r[i+1]    <= m_r_r;
        s_q_r[i+1]    <= m_q_r;
        s_zero_r[i+1] <= m_zero_r;
        s_side_r[i+1] <= m_side_r;
      end
    end
  end

  // scale by 2^-q, or zero when the exponent is out of range
  logic          ve_r;
  logic [32:0]   e_r;
  logic [SW-1:0] side_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= s_v_r[EXP_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r      <= s_zero_r[EXP_TERMS] ? 33'd0 : (t_r[EXP_TERMS] >> s_q_r[EXP_TERMS]);
      side_e_r <= s_side_r[EXP_TERMS];
    end
  end

  assign out_valid = ve_r;
  assign e_o       = e_r;
  assign side_o    = side_e_r;

endmodule

// File: rtl/sif_update.sv
module sif_update
  import sif_pkg::*;
#(
  parameter int VALUE_WIDTH = SIF_VALUE_WIDTH,
  parameter int SW          = 6 * VALUE_WIDTH + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [32:0]            e_i,
  input  logic [SW-1:0]          side_i,
  input  logic                   first_step,
  input  logic [31:0]            time_step,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] new_re,
  output logic [VALUE_WIDTH-1:0] new_im,
  output logic                   updated
);

  localparam int VW = VALUE_WIDTH;
  localparam int PW = VW + 34;
  localparam int QW = VW + 2;
  localparam int AW = VW + 4;
  localparam logic signed [AW-1:0] VMAX = {{5{1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [AW-1:0] VMIN = {{5{1'b1}}, {(VW-1){1'b0}}};

  logic          v0_r, v1_r, v2_r, v3_r;
  logic [63:0]   dte_r;
  logic [32:0]   e0_r, e1_r;
  logic [SW-1:0] side0_r, side1_r, side2_r;
  logic [32:0]   cg_r, cg_nxt;
  logic [31:0]   co_r, co_nxt;
  logic [30:0]   h;
  logic [63:0]   eh;
  logic [64:0]   dte_full;

  // dt * e
  assign dte_full = 65'(time_step) * 65'(e_i);

  // step coefficients
  always_comb begin
    h      = dte_r[63:33];
    eh     = 64'(e0_r) * 64'(h);
    cg_nxt = first_step ? {1'b0, dte_r[63:32]} : (33'(h) + 33'({h, 1'b0}));
    co_nxt = first_step ? 32'd0 : eh[63:32];
  end

  // signed products floored back to q8.24
  logic signed [VW-1:0] u_re, u_im, g_re, g_im, o_re, o_im;
  logic signed [PW-1:0] pu_re, pu_im, pg_re, pg_im, po_re, po_im;
  logic signed [QW-1:0] qu_re_r, qu_im_r, qg_re_r, qg_im_r, qo_re_r, qo_im_r;

  always_comb begin
    u_re  = side1_r[6*VW-1 -: VW];
    u_im  = side1_r[5*VW-1 -: VW];
    g_re  = side1_r[4*VW-1 -: VW];
    g_im  = side1_r[3*VW-1 -: VW];
    o_re  = side1_r[2*VW-1 -: VW];
    o_im  = side1_r[VW-1:0];
    pu_re = PW'(u_re) * PW'($signed({1'b0, e1_r}));
    pu_im = PW'(u_im) * PW'($signed({1'b0, e1_r}));
    pg_re = PW'(g_re) * PW'($signed({1'b0, cg_r}));
    pg_im = PW'(g_im) * PW'($signed({1'b0, cg_r}));
    po_re = PW'(o_re) * PW'($signed({1'b0, co_r}));
    po_im = PW'(o_im) * PW'($signed({1'b0, co_r}));
  end

  // sum and saturate; modes outside the retained set pass the velocity through
  logic signed [AW-1:0]  sum_re, sum_im;
  logic [VW-1:0]         res_re, res_im;
  logic                  keep2;

  always_comb begin
    keep2  = side2_r[SW-1];
    sum_re = AW'(qu_re_r) + AW'(qg_re_r) - AW'(qo_re_r);
    sum_im = AW'(qu_im_r) + AW'(qg_im_r) - AW'(qo_im_r);
    if (!keep2) begin
      res_re = side2_r[6*VW-1 -: VW];
    end else if (sum_re > VMAX) begin
      res_re = VMAX[VW-1:0];
    end else if (sum_re < VMIN) begin
      res_re = VMIN[VW-1:0];
    end else begin
      res_re = sum_re[VW-1:0];
    end
    if (!keep2) begin
      res_im = side2_r[5*VW-1 -: VW];
    end else if (sum_im > VMAX) begin
      res_im = VMAX[VW-1:0];
    end else if (sum_im < VMIN) begin
      res_im = VMIN[VW-1:0];
    end else begin
      res_im = sum_im[VW-1:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // data stages, last one is the output register
  always_ff @(posedge clk) begin
    if (en) begin
      dte_r   <= dte_full[63:0];
      e0_r    <= e_i;
      side0_r <= side_i;
      cg_r    <= cg_nxt;
      co_r    <= co_nxt;
      e1_r    <= e0_r;
      side1_r <= side0_r;
      qu_re_r <= QW'(pu_re >>> 32);
      qu_im_r <= QW'(pu_im >>> 32);
      qg_re_r <= QW'(pg_re >>> 32);
      qg_im_r <= QW'(pg_im >>> 32);
      qo_re_r <= QW'(po_re >>> 32);
      qo_im_r <= QW'(po_im >>> 32);
      side2_r <= side1_r;
      new_re  <= res_re;
      new_im  <= res_im;
      updated <= keep2;
    end
  end

  assign out_valid = v3_r;

endmodule

// File: rtl/spectral_integrating_factor_step.sv
// Integrating-factor time step for one spectral velocity coefficient per transaction.
// A fully pipelined datapath: a new transaction is taken every cycle while the output
// is not stalled; most of the depth is the twelve-term exponential series, two register
// stages per term (one multiply, one reciprocal divide). A stalled output freezes the
// whole pipeline. Configuration writes are taken at any time but must only be issued
// while the pipeline is empty; all but the mode count act from the next cycle on.
module spectral_integrating_factor_step
  import sif_pkg::*;
#(
  parameter int MAX_MODES   = SIF_MAX_MODES,
  parameter int VALUE_WIDTH = SIF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_wave_a,
  input  logic [7:0]             in_wave_b,
  input  logic [7:0]             in_wave_c,
  input  logic [VALUE_WIDTH-1:0] in_vel_re,
  input  logic [VALUE_WIDTH-1:0] in_vel_im,
  input  logic [VALUE_WIDTH-1:0] in_force_re,
  input  logic [VALUE_WIDTH-1:0] in_force_im,
  input  logic [VALUE_WIDTH-1:0] in_prev_force_re,
  input  logic [VALUE_WIDTH-1:0] in_prev_force_im,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_new_re,
  output logic [VALUE_WIDTH-1:0] out_new_im,
  output logic                   out_updated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int SW = 6 * VALUE_WIDTH + 1;

  // configuration registers
  logic        first_step_r;
  logic [31:0] time_step_r, viscous_rate_r;
  logic [8:0]  mode_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_step_r   <= 1'b1;
      time_step_r    <= 32'd0;
      viscous_rate_r <= 32'd0;
      mode_count_r   <= 9'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FIRST_STEP:   first_step_r   <= cfg_data[0];
        CFG_TIME_STEP:    time_step_r    <= cfg_data;
        CFG_VISCOUS_RATE: viscous_rate_r <= cfg_data;
        CFG_MODE_COUNT:   mode_count_r   <= cfg_data[8:0];
        default:          ;
      endcase
    end
  end

  // clamped mode count and truncation limit, floor(4k/3) by reciprocal
  logic [8:0]  k_r, k_nxt;
  logic [9:0]  lim_r;
  logic [27:0] lim_prod;

  always_comb begin
    k_nxt    = ({2'b0, mode_count_r} > 11'(MAX_MODES)) ? 9'(MAX_MODES) : mode_count_r;
    lim_prod = 28'({k_nxt, 2'b00}) * 28'(17'h0AAAB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= 9'd64;
      lim_r <= 10'd85;
    end else begin
      k_r   <= k_nxt;
      lim_r <= lim_prod[26:17];
    end
  end

  // global advance
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic          fr_valid, dec_valid;
  logic [49:0]   fr_x;
  logic [SW-1:0] fr_side, dec_side;
  logic [32:0]   dec_e;

  sif_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .SW          (SW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid && in_ready),
    .wave_a       (in_wave_a),
    .wave_b       (in_wave_b),
    .wave_c       (in_wave_c),
    .pay          ({in_vel_re, in_vel_im, in_force_re, in_force_im,
                    in_prev_force_re, in_prev_force_im}),
    .k_i          (k_r),
    .lim_i        (lim_r),
    .viscous_rate (viscous_rate_r),
    .out_valid    (fr_valid),
    .x_o          (fr_x),
    .side_o       (fr_side)
  );

  sif_decay #(
    .SW (SW)
  ) u_decay (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .x_i       (fr_x),
    .side_i    (fr_side),
    .out_valid (dec_valid),
    .e_o       (dec_e),
    .side_o    (dec_side)
  );

  sif_update #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .SW          (SW)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (dec_valid),
    .e_i        (dec_e),
    .side_i     (dec_side),
    .first_step (first_step_r),
    .time_step  (time_step_r),
    .out_valid  (out_valid),
    .new_re     (out_new_re),
    .new_im     (out_new_im),
    .updated    (out_updated)
  );

`ifndef ASSERT_OFF
  // decay factor never exceeds one
  assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid |-> (dec_e <= ONE_Q32))
    else $error("decay factor above one");

  // pipeline comes out of reset empty
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a held result stays valid and unchanged until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_new_re) &&
                                   $stable(out_new_im) && $stable(out_updated)))
    else $error("held result lost");
`endif

endmodule

// File: sim/tb_spectral_integrating_factor_step.sv
module tb_spectral_integrating_factor_step
  import sif_pkg::*;
();

  localparam logic [63:0] UNIT_Q32   = 64'h1_0000_0000;
  localparam logic [63:0] LOG2_Q32   = 64'hB172_17F8;
  localparam int          SERIES_LEN = 12;
  localparam int          MODE_LIMIT = 256;
  localparam logic [2:0]  CFG_SPARE  = 3'd5;
  localparam int          RAND_ITEMS = 120;

  typedef struct {
    logic [7:0]  wa, wb, wc;
    logic [31:0] u_re, u_im, g_re, g_im, o_re, o_im;
    bit          typed;
    logic [31:0] e_re, e_im;
    logic        e_upd;
  } coef_row_t;

  typedef struct {
    logic [31:0] re, im;
    logic        upd;
  } coef_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_wave_a = '0, in_wave_b = '0, in_wave_c = '0;
  logic [31:0] in_vel_re = '0, in_vel_im = '0, in_force_re = '0, in_force_im = '0;
  logic [31:0] in_prev_force_re = '0, in_prev_force_im = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_new_re, out_new_im;
  logic        out_updated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the registers
  logic        m_first = 1'b1;
  logic [31:0] m_dt = '0, m_vr = '0;
  logic [8:0]  m_k = 9'd64;

  coef_res_t   pending_q[$];
  coef_row_t   cur_row;
  int          errors = 0, items_sent = 0, results_seen = 0, advanced = 0;
  int          hold_token = 0;
  int          burst_left = 0;

  spectral_integrating_factor_step i_dut (.*);

  always #5 clk = ~clk;

  // exponential decay factor, q0.32 with 1.0 as 2^32
  function automatic logic [63:0] decay_factor(input logic [63:0] x);
    logic [63:0] q, r, t;
    q = x / LOG2_Q32;
    if (q > 64'd32) return 64'd0;
    r = x - q * LOG2_Q32;
    t = UNIT_Q32;
    for (int n = SERIES_LEN; n >= 1; n--) t = UNIT_Q32 - (((r * t) >> 32) / 64'(n));
    return t >> q;
  endfunction

  // floored product of a q8.24 value with a q0.32 coefficient
  function automatic logic signed [63:0] scale(input logic [31:0] v, input logic [63:0] cf);
    logic signed [127:0] p;
    p = $signed({{96{v[31]}}, v}) * $signed({64'd0, cf});
    return 64'(p >>> 32);
  endfunction

  function automatic logic [31:0] clamp(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic coef_res_t advance_coef(input coef_row_t r);
    coef_res_t res;
    logic [9:0]  k, lim;
    logic [63:0] ksq, e, dte, ca, cb;
    logic signed [63:0] s_re, s_im;
    bit keep;
    k   = (m_k > MODE_LIMIT) ? 10'(MODE_LIMIT) : 10'(m_k);
    lim = 10'((4 * k) / 3);
    keep = r.wa < k && r.wb < k && r.wc < k && (r.wa | r.wb | r.wc) != 0 &&
           10'(r.wa) + r.wb <= lim && 10'(r.wa) + r.wc <= lim && 10'(r.wb) + r.wc <= lim;
    res.re = r.u_re; res.im = r.u_im; res.upd = keep;
    if (keep) begin
      ksq = 64'(r.wa) * r.wa + 64'(r.wb) * r.wb + 64'(r.wc) * r.wc;
      e   = decay_factor(ksq * 64'(m_vr));
      dte = 64'(m_dt) * e;
      if (m_first) begin
        s_re = scale(r.u_re, e) + scale(r.g_re, dte >> 32);
        s_im = scale(r.u_im, e) + scale(r.g_im, dte >> 32);
      end else begin
        ca = 3 * (dte >> 33);
        cb = (e * (dte >> 33)) >> 32;
        s_re = scale(r.u_re, e) + scale(r.g_re, ca) - scale(r.o_re, cb);
        s_im = scale(r.u_im, e) + scale(r.g_im, ca) - scale(r.o_im, cb);
      end
      res.re = clamp(s_re);
      res.im = clamp(s_im);
    end
    return res;
  endfunction

  // accepted transactions: predict on input, check on output, track registers
  always @(posedge clk) begin
    coef_res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIRST_STEP:   m_first <= cfg_data[0];
          CFG_TIME_STEP:    m_dt    <= cfg_data;
          CFG_VISCOUS_RATE: m_vr    <= cfg_data;
          CFG_MODE_COUNT:   m_k     <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (cur_row.typed) begin
          want.re = cur_row.e_re; want.im = cur_row.e_im; want.upd = cur_row.e_upd;
        end else begin
          want = advance_coef(cur_row);
        end
        pending_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_updated) advanced++;
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result re=%h im=%h", out_new_re, out_new_im);
        end else begin
          want = pending_q.pop_front();
          if (want.re !== out_new_re || want.im !== out_new_im || want.upd !== out_updated) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: want re=%h im=%h upd=%b, got re=%h im=%h upd=%b",
                       want.re, want.im, want.upd, out_new_re, out_new_im, out_updated);
          end
        end
      end
    end
  end

  // result side stalls on its own pattern, with a long hold-off on request
  always @(posedge clk) begin
    static int seen = 0, hold_left = 0, pat_left = 0, pat_mode = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_token != seen) begin
        seen = hold_token;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(10, 80);
        end
        pat_left--;
        case (pat_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one coefficient, in bursts with random gaps
  task automatic send_coef(input coef_row_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cur_row <= r;
    in_wave_a <= r.wa; in_wave_b <= r.wb; in_wave_c <= r.wc;
    in_vel_re <= r.u_re; in_vel_im <= r.u_im;
    in_force_re <= r.g_re; in_force_im <= r.g_im;
    in_prev_force_re <= r.o_re; in_prev_force_im <= r.o_im;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // drain the pipeline before touching registers
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_seen < items_sent) begin
      @(posedge clk);
      waited++;
      if (waited > 200000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic coef_row_t rand_row();
    coef_row_t r;
    int k, span;
    k = (m_k > MODE_LIMIT) ? MODE_LIMIT : int'(m_k);
    span = (k - 1 < (4 * k / 3) / 2) ? k - 1 : (4 * k / 3) / 2;
    if (span < 0) span = 0;
    if (span > 255) span = 255;
    if ($urandom_range(0, 3) != 0) begin
      r.wa = 8'($urandom_range(0, span)); r.wb = 8'($urandom_range(0, span));
      r.wc = 8'($urandom_range(0, span));
    end else begin
      r.wa = 8'($urandom); r.wb = 8'($urandom); r.wc = 8'($urandom);
    end
    r.u_re = rand_value(); r.u_im = rand_value();
    r.g_re = rand_value(); r.g_im = rand_value();
    r.o_re = rand_value(); r.o_im = rand_value();
    r.typed = 1'b0; r.e_re = '0; r.e_im = '0; r.e_upd = 1'b0;
    return r;
  endfunction

  // directed rows at reset settings: unit decay and zero step leave U unchanged
  coef_row_t reset_rows[] = '{
    '{8'd1, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h1, 32'h2, 32'h3,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1},
    '{8'd0, 8'd0, 8'd0, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h0, 32'h0, 1'b1, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0},
    '{8'd64, 8'd1, 8'd1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0},
    '{8'd63, 8'd0, 8'd0, 32'h0100_0000, 32'hFF00_0000, 32'h1, 32'h1, 32'h1, 32'h1,
      1'b1, 32'h0100_0000, 32'hFF00_0000, 1'b1},
    '{8'd43, 8'd43, 8'd0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0},
    '{8'd42, 8'd43, 8'd42, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1},
    '{8'd255, 8'd255, 8'd255, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
      32'h0, 32'h0, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0},
    '{8'd0, 8'd63, 8'd22, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1}
  };

  // extreme rows: huge decay clears kept modes, dropped modes pass, rest predicted
  coef_row_t extreme_rows[] = '{
    '{8'd200, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h1, 32'h1, 1'b1, 32'h0, 32'h0, 1'b1},
    '{8'd255, 8'd1, 8'd0, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h0, 32'h0, 1'b1},
    '{8'd255, 8'd255, 8'd0, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h1234_5678, 32'h8765_4321, 1'b0},
    '{8'd1, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{8'd0, 8'd0, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0}
  };

  // main sequence: directed table, then random phases over several settings
  initial begin
    static logic [31:0] ph_cfg [7][4] = '{
      '{32'd1, 32'h1000_0000, 32'h0000_1000, 32'd64},
      '{32'd0, 32'h0800_0000, 32'h0001_0000, 32'd32},
      '{32'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'd256},
      '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2},
      '{32'd0, 32'h4000_0000, 32'h0000_0400, 32'hFFFF_FFFF},
      '{32'd1, 32'h0000_0000, 32'h0000_8000, 32'd1},
      '{32'd0, 32'h2000_0000, 32'h0000_0100, 32'd0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (reset_rows[i]) send_coef(reset_rows[i]);
    drain();

    // first_step low, widest dt and decay, largest K; extremes saturate
    cfg_write(CFG_FIRST_STEP, 32'h0);
    cfg_write(CFG_TIME_STEP, 32'hFFFF_FFFF);
    cfg_write(CFG_VISCOUS_RATE, 32'hFFFF_FFFF);
    cfg_write(CFG_MODE_COUNT, 32'd256);
    for (int i = 0; i < 2; i++) send_coef(extreme_rows[i]);
    send_coef(extreme_rows[2]);
    drain();
    cfg_write(CFG_VISCOUS_RATE, 32'h0);
    for (int i = 3; i < 5; i++) send_coef(extreme_rows[i]);
    drain();

    for (int p = 0; p < 7; p++) begin
      cfg_write(CFG_FIRST_STEP, ph_cfg[p][0]);
      cfg_write(CFG_TIME_STEP, (p == 6) ? $urandom : ph_cfg[p][1]);
      cfg_write(CFG_VISCOUS_RATE, (p == 6) ? ($urandom >> $urandom_range(10, 31))
                                             : ph_cfg[p][2]);
      cfg_write(CFG_MODE_COUNT, (p == 6) ? 32'($urandom_range(2, 256)) : ph_cfg[p][3]);
      // a write to an index past the list must change nothing
      if (p == 4) cfg_write(CFG_SPARE, $urandom);
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (p == 2 && i == 10) hold_token++;
        send_coef(rand_row());
      end
      drain();
    end

    $display("sent %0d coefficients over 10 register settings, %0d results, %0d advanced",
             items_sent, results_seen, advanced);
    $display("%0d mismatches", errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
